// ----- rtl/greedy_trajectory_linker_top_assert.svh -----
// Assertion macros for the trajectory linker.
`ifndef GREEDY_TRAJECTORY_LINKER_TOP_ASSERT_SVH
`define GREEDY_TRAJECTORY_LINKER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define GTL_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("gtl assertion failed");
// Check a property on every clock edge, reset included.
`define GTL_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("gtl assertion failed");
`else
`define GTL_ASSERT(name, clk, rstn, prop)
`define GTL_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ----- rtl/gtl_pkg.sv -----
package gtl_pkg;

    localparam int MAX_PARTICLES     = 64;
    localparam int POS_W             = 6;
    localparam int CNT_W             = 7;
    localparam int ID_W              = 32;
    localparam int DIST_IN_W         = 24;
    localparam int MAX_LINKS_DEF     = 256;
    localparam int DIST_BITS_DEF     = 24;
    localparam int IN_DATA_W         = 48;
    localparam int OUT_DATA_W        = 40;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_CLOSE   = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_XFER,
        ST_CALC,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_EMIT_WAIT
    } state_t;

endpackage

// ----- rtl/greedy_trajectory_linker_top.sv -----
// Channel   Dir  Beat content
// s_axis    in   tuser: op; tdata: prev_pos, new_pos, distance, frame_size
// m_axis    out  tdata: pos_index, traj_id; tuser: flags; tlast: last of frame
// cfg       in   cfg_data: first_count, always ready
// An add or restart keeps the block idle; the next beat is taken on the following cycle.
// A close scans the link store once per accepted link plus once more, bound by
// the single read port of the link store; the results then also wait on any
// output stall.
// Reset (rst_n low, asynchronous) empties the store and gives the identity map.
// A stalled result holds the block; no input is taken until the frame is out.
`include "greedy_trajectory_linker_top_assert.svh"

module greedy_trajectory_linker_top #(
    parameter int MAX_LINKS = gtl_pkg::MAX_LINKS_DEF,
    parameter int DIST_BITS = gtl_pkg::DIST_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // prev_pos[5:0], new_pos[11:6], distance[35:12], frame_size[42:36], zero
    input  logic [gtl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pos_index[5:0], traj_id[37:6], zero
    output logic [gtl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // is_new[0], links_dropped[1], ids_exhausted[2]
    output logic [2:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gtl_pkg::CNT_W-1:0]      cfg_data
);
    import gtl_pkg::*;

    localparam int LA_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int LC_W = $clog2(MAX_LINKS + 1);
    localparam int LK_W = 2 * POS_W + DIST_BITS;
    localparam int DX_W = (DIST_BITS > DIST_IN_W) ? DIST_BITS : DIST_IN_W;

    // Memories
    logic [LK_W-1:0] link_mem [MAX_LINKS];
    logic [ID_W-1:0] prev_traj_mem [MAX_PARTICLES];
    logic [ID_W-1:0] new_traj_mem [MAX_PARTICLES];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   first_count_reg;
    logic [CNT_W-1:0]   prev_count_reg, prev_count_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [LC_W-1:0]    link_count_reg, link_count_next;
    logic [MAX_PARTICLES-1:0] new_taken_reg, new_taken_next;
    logic [MAX_PARTICLES-1:0] prev_taken_reg, prev_taken_next;
    logic               overflow_reg, overflow_next;
    logic               ident_reg, ident_next;
    logic [CNT_W-1:0]   fs_reg, fs_next;
    logic [LC_W-1:0]    scan_addr_reg, scan_addr_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               best_found_reg, best_found_next;
    logic [DIST_BITS-1:0] best_dist_reg, best_dist_next;
    logic [POS_W-1:0]   best_prev_reg, best_prev_next;
    logic [POS_W-1:0]   best_new_reg, best_new_next;
    logic [CNT_W-1:0]   accept_cnt_reg, accept_cnt_next;
    logic               exh_reg, exh_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic               out_new_reg, out_new_next;
    logic               out_last_reg, out_last_next;

    logic [LK_W-1:0]    lk_rdata_reg;
    logic [ID_W-1:0]    pt_rdata_reg;
    logic [ID_W-1:0]    nt_rdata_reg;

    logic               lk_we;
    logic [LK_W-1:0]    lk_wdata;
    logic               nt_we;
    logic [ID_W-1:0]    nt_wdata;
    logic               pt_we;
    logic [ID_W-1:0]    pt_wdata;

    // Input field views
    logic [1:0]           in_op;
    logic [POS_W-1:0]     in_prev;
    logic [POS_W-1:0]     in_new;
    logic [DIST_IN_W-1:0] in_dist;
    logic [CNT_W-1:0]     in_fs;
    logic [DX_W-1:0]      dist_ext;
    logic                 in_fire;
    logic                 out_fire;

    // Link store read fields
    logic [POS_W-1:0]     rd_prev;
    logic [POS_W-1:0]     rd_new;
    logic [DIST_BITS-1:0] rd_dist;
    logic                 rd_ok;
    logic                 rd_better;

    logic [CNT_W-1:0]     fresh_cnt;
    logic [ID_W:0]        id_sum;
    logic                 pos_taken;
    logic [ID_W-1:0]      pos_id;

    assign in_op    = s_axis_tuser;
    assign in_prev  = s_axis_tdata[POS_W-1:0];
    assign in_new   = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_dist  = s_axis_tdata[2*POS_W+DIST_IN_W-1:2*POS_W];
    assign in_fs    = s_axis_tdata[2*POS_W+DIST_IN_W+CNT_W-1:2*POS_W+DIST_IN_W];
    assign dist_ext = DX_W'(in_dist);
    assign lk_wdata = {dist_ext[DIST_BITS-1:0], in_new, in_prev};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-ID_W-POS_W){1'b0}}, out_id_reg, pos_reg};
    assign m_axis_tuser  = {exh_reg, overflow_reg, out_new_reg};
    assign m_axis_tlast  = out_last_reg;

    assign rd_prev = lk_rdata_reg[POS_W-1:0];
    assign rd_new  = lk_rdata_reg[2*POS_W-1:POS_W];
    assign rd_dist = lk_rdata_reg[LK_W-1:2*POS_W];
    assign rd_ok   = ({1'b0, rd_prev} < prev_count_reg) && ({1'b0, rd_new} < fs_reg)
                     && !prev_taken_reg[rd_prev] && !new_taken_reg[rd_new];
    assign rd_better = !best_found_reg
                       || ({rd_dist, rd_prev} < {best_dist_reg, best_prev_reg});

    assign fresh_cnt = fs_reg - accept_cnt_reg;
    assign id_sum    = {1'b0, next_id_reg} + {{(ID_W+1-CNT_W){1'b0}}, fresh_cnt};
    assign pos_taken = new_taken_reg[pos_reg];
    assign pos_id    = pos_taken ? nt_rdata_reg : next_id_reg;

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            first_count_reg <= cfg_data;
        end
    end

    // Link store: append on add, scan on close
    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            link_mem[link_count_reg[LA_W-1:0]] <= lk_wdata;
        end
        lk_rdata_reg <= link_mem[scan_addr_reg[LA_W-1:0]];
    end

    // Trajectory ids of the previous frame
    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            prev_traj_mem[pos_reg] <= pt_wdata;
        end
        pt_rdata_reg <= prev_traj_mem[best_prev_reg];
    end

    // Trajectory ids handed to the new frame
    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            new_traj_mem[best_new_reg] <= nt_wdata;
        end
        nt_rdata_reg <= new_traj_mem[pos_reg];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_count_reg <= '0;
            next_id_reg    <= '0;
            link_count_reg <= '0;
            new_taken_reg  <= '0;
            prev_taken_reg <= '0;
            overflow_reg   <= 1'b0;
            ident_reg      <= 1'b1;
            fs_reg         <= '0;
            scan_addr_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            accept_cnt_reg <= '0;
            exh_reg        <= 1'b0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_count_reg <= prev_count_next;
            next_id_reg    <= next_id_next;
            link_count_reg <= link_count_next;
            new_taken_reg  <= new_taken_next;
            prev_taken_reg <= prev_taken_next;
            overflow_reg   <= overflow_next;
            ident_reg      <= ident_next;
            fs_reg         <= fs_next;
            scan_addr_reg  <= scan_addr_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            accept_cnt_reg <= accept_cnt_next;
            exh_reg        <= exh_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        best_dist_reg <= best_dist_next;
        best_prev_reg <= best_prev_next;
        best_new_reg  <= best_new_next;
        out_id_reg    <= out_id_next;
        out_new_reg   <= out_new_next;
        out_last_reg  <= out_last_next;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        prev_count_next = prev_count_reg;
        next_id_next    = next_id_reg;
        link_count_next = link_count_reg;
        new_taken_next  = new_taken_reg;
        prev_taken_next = prev_taken_reg;
        overflow_next   = overflow_reg;
        ident_next      = ident_reg;
        fs_next         = fs_reg;
        scan_addr_next  = scan_addr_reg;
        rd_pend_next    = 1'b0;
        best_found_next = best_found_reg;
        best_dist_next  = best_dist_reg;
        best_prev_next  = best_prev_reg;
        best_new_next   = best_new_reg;
        accept_cnt_next = accept_cnt_reg;
        exh_next        = exh_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_new_next    = out_new_reg;
        out_last_next   = out_last_reg;
        lk_we           = 1'b0;
        nt_we           = 1'b0;
        nt_wdata        = ident_reg ? ID_W'(best_prev_reg) : pt_rdata_reg;
        pt_we           = 1'b0;
        pt_wdata        = pos_id;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op_t'(in_op))
                        OP_ADD:
                        begin
                            if (link_count_reg < LC_W'(MAX_LINKS))
                            begin
                                lk_we           = 1'b1;
                                link_count_next = link_count_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        OP_CLOSE:
                        begin
                            fs_next         = (in_fs > CNT_W'(MAX_PARTICLES))
                                              ? CNT_W'(MAX_PARTICLES) : in_fs;
                            new_taken_next  = '0;
                            prev_taken_next = '0;
                            accept_cnt_next = '0;
                            scan_addr_next  = '0;
                            best_found_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        OP_RESTART:
                        begin
                            prev_count_next = (first_count_reg > CNT_W'(MAX_PARTICLES))
                                              ? CNT_W'(MAX_PARTICLES) : first_count_reg;
                            next_id_next    = ID_W'(prev_count_next);
                            ident_next      = 1'b1;
                            link_count_next = '0;
                            overflow_next   = 1'b0;
                            new_taken_next  = '0;
                            prev_taken_next = '0;
                        end
                        OP_NONE:
                        begin
                        end
                    endcase
                end
            end

            // Walk the store and keep the best link whose ends are still free
            ST_SCAN:
            begin
                if (scan_addr_reg < link_count_reg)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                    rd_pend_next   = 1'b1;
                end
                if (rd_pend_reg && rd_ok && rd_better)
                begin
                    best_found_next = 1'b1;
                    best_dist_next  = rd_dist;
                    best_prev_next  = rd_prev;
                    best_new_next   = rd_new;
                end
                if (!rd_pend_reg && (scan_addr_reg == link_count_reg))
                begin
                    state_next = ST_PICK;
                end
            end

            // Accept the winner or finish linking
            ST_PICK:
            begin
                if (best_found_reg)
                begin
                    prev_taken_next[best_prev_reg] = 1'b1;
                    new_taken_next[best_new_reg]   = 1'b1;
                    accept_cnt_next                = accept_cnt_reg + 1'b1;
                    state_next                     = ST_XFER;
                end
                else
                begin
                    state_next = ST_CALC;
                end
            end

            // Pass the id of the previous position on
            ST_XFER:
            begin
                nt_we           = 1'b1;
                scan_addr_next  = '0;
                best_found_next = 1'b0;
                state_next      = ST_SCAN;
            end

            // Work out the final counter for the exhaustion flag; an empty frame returns to idle
            ST_CALC:
            begin
                exh_next = (id_sum >= {1'b0, ID_MAX});
                pos_next = '0;
                if (fs_reg == '0)
                begin
                    prev_count_next = '0;
                    link_count_next = '0;
                    overflow_next   = 1'b0;
                    new_taken_next  = '0;
                    prev_taken_next = '0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end

            // Form the result and write it back as the next previous frame
            ST_EMIT_WR:
            begin
                pt_we          = 1'b1;
                out_valid_next = 1'b1;
                out_id_next    = pos_id;
                out_new_next   = !pos_taken;
                out_last_next  = ({1'b0, pos_reg} == (fs_reg - 1'b1));
                if (!pos_taken && (next_id_reg != ID_MAX))
                begin
                    next_id_next = next_id_reg + 1'b1;
                end
                state_next = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        prev_count_next = fs_reg;
                        ident_next      = 1'b0;
                        link_count_next = '0;
                        overflow_next   = 1'b0;
                        new_taken_next  = '0;
                        prev_taken_next = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `GTL_ASSERT(a_out_only_in_emit, clk, rst_n, out_valid_reg |-> (state_reg == ST_EMIT_WAIT))
    `GTL_ASSERT(a_store_bound, clk, rst_n, link_count_reg <= LC_W'(MAX_LINKS))
    `GTL_ASSERT(a_accept_bound, clk, rst_n, accept_cnt_reg <= fs_reg)
    `GTL_ASSERT_ALWAYS(a_no_input_while_out, clk, !(out_valid_reg && s_axis_tready))

endmodule
